// ----- rtl/rdd_pkg.sv -----
// ----------------------------------------------------------------------------
// rdd_pkg: shared types and constants of the recurring decimal divider
// Widths, result kind codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rdd_pkg;

    localparam int MAX_DEN_DEF = 64;
    localparam int NUM_W_DEF   = 16;
    localparam int DEN_W       = 7;
    localparam int VALUE_W     = 16;
    localparam int KIND_W      = 2;
    localparam int DIGIT_W     = 4;
    localparam int RADIX       = 10;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT   = 2'd0,
        KIND_DIGIT = 2'd1,
        KIND_ERR   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_DIV,
        S_INT,
        S_DIGIT,
        S_CAPTURE,
        S_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic dig_step;
        logic take_start;
        logic rd_first;
        logic rd_next;
        logic emit_int;
        logic emit_dig;
        logic emit_err;
    } t_cmd;

    typedef struct packed {
        logic den_bad;
        logic div_last;
        logic rem_zero;
        logic seen_hit;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/rdd_in_if.sv -----
// ----------------------------------------------------------------------------
// rdd_in_if: input channel of the recurring decimal divider
// One word carries a numerator and a denominator.
// ----------------------------------------------------------------------------
interface rdd_in_if import rdd_pkg::*; #(
    parameter int NUM_W = NUM_W_DEF
);
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] numerator;
    logic [DEN_W-1:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// ----- rtl/rdd_out_if.sv -----
// ----------------------------------------------------------------------------
// rdd_out_if: result channel of the recurring decimal divider
// One word carries an integer part, a fractional digit or an error.
// ----------------------------------------------------------------------------
interface rdd_out_if import rdd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               repeat_start;
    logic               repeat_end;
    logic               last;

    modport source (output valid, output kind, output value, output repeat_start,
                    output repeat_end, output last, input ready);
    modport sink   (input valid, input kind, input value, input repeat_start,
                    input repeat_end, input last, output ready);
endinterface

// ----- rtl/rdd_ram.sv -----
// ----------------------------------------------------------------------------
// rdd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; the read
// data holds while no read is enabled.
// ----------------------------------------------------------------------------
module rdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdd_ctrl: sequencer of the recurring decimal divider
// Steps one item through integer division, digit generation with repeat
// detection, and emission of the buffered digits.
// ----------------------------------------------------------------------------
module rdd_ctrl import rdd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.den_bad ? S_ERR : S_DIV;
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_INT;
                end
            end
            S_INT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_int = 1'b1;
                    n_state        = i_stat.rem_zero ? S_IDLE : S_DIGIT;
                end
            end
            S_DIGIT: begin
                // zero remainder ends the expansion; a seen remainder closes a cycle
                priority if (i_stat.rem_zero) begin
                    n_state = S_RD;
                end else if (i_stat.seen_hit) begin
                    n_state = S_CAPTURE;
                end else begin
                    o_cmd.dig_step = 1'b1;
                end
            end
            S_CAPTURE: begin
                o_cmd.take_start = 1'b1;
                n_state          = S_RD;
            end
            S_RD: begin
                o_cmd.rd_first = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_dig = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rdd_datapath.sv -----
// ----------------------------------------------------------------------------
// rdd_datapath: arithmetic and storage of the recurring decimal divider
// Bit-serial integer divider, combinational decimal digit step, seen-remainder
// flags and position table, digit buffer and the output word register.
// ----------------------------------------------------------------------------
module rdd_datapath import rdd_pkg::*; #(
    parameter int MAX_DEN = MAX_DEN_DEF,
    parameter int NUM_W   = NUM_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NUM_W-1:0]   i_numerator,
    input  logic [DEN_W-1:0]   i_denominator,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [KIND_W-1:0]  o_kind,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_repeat_start,
    output logic               o_repeat_end,
    output logic               o_last
);

    localparam int IDX_W  = $clog2(MAX_DEN);
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int QW     = (NUM_W > VALUE_W) ? NUM_W : VALUE_W;
    localparam int PROD_W = DEN_W + 4;

    // one decimal digit of 10*r / den, with the new remainder, by four trial subtracts
    function automatic logic [DIGIT_W+DEN_W-1:0] digit_step(
        input logic [DEN_W-1:0] rem,
        input logic [DEN_W-1:0] den
    );
        logic [PROD_W-1:0]  acc;
        logic [PROD_W-1:0]  trial;
        logic [DIGIT_W-1:0] q;
        acc = PROD_W'(rem) * PROD_W'(RADIX);
        q   = '0;
        for (int k = DIGIT_W - 1; k >= 0; k--) begin
            trial = PROD_W'(den) << k;
            if (acc >= trial) begin
                acc  = acc - trial;
                q[k] = 1'b1;
            end
        end
        return {q, acc[DEN_W-1:0]};
    endfunction

    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_bits;
    logic [IDX_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_start;
    logic               r_repeating;
    logic [MAX_DEN-1:0] r_seen;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [VALUE_W-1:0] r_value;
    logic               r_rs;
    logic               r_re;
    logic               r_last;

    logic [DEN_W-1:0]   div_shift;
    logic               div_ge;
    logic [DEN_W-1:0]   div_rem;
    logic [DIGIT_W-1:0] dig_q;
    logic [DEN_W-1:0]   dig_rem;
    logic [IDX_W-1:0]   rem_idx;
    logic [QW-1:0]      q_ext;
    logic [VALUE_W-1:0] q_val;
    logic               emit_last;
    logic               out_free;
    logic [IDX_W-1:0]   seen_rdata;
    logic [DIGIT_W-1:0] dig_rdata;
    logic               dig_re;
    logic [IDX_W-1:0]   dig_raddr;

    // restoring division, one quotient bit per cycle shifted into r_num
    assign div_shift = {r_rem[DEN_W-2:0], r_num[NUM_W-1]};
    assign div_ge    = div_shift >= r_den;
    assign div_rem   = div_ge ? div_shift - r_den : div_shift;

    assign {dig_q, dig_rem} = digit_step(r_rem, r_den);
    assign rem_idx          = r_rem[IDX_W-1:0];

    assign q_ext = QW'(r_num);
    assign q_val = ((q_ext >> VALUE_W) != '0) ? '1 : q_ext[VALUE_W-1:0];

    assign emit_last = r_idx == (r_count - IDX_W'(1));
    assign out_free  = !r_out_valid || i_out_ready;

    assign dig_re    = i_cmd.rd_first || i_cmd.rd_next;
    assign dig_raddr = i_cmd.rd_first ? '0 : r_idx + IDX_W'(1);

    assign o_stat.den_bad   = (i_denominator == '0) || (i_denominator > DEN_W'(MAX_DEN));
    assign o_stat.div_last  = r_bits == CNT_W'(NUM_W - 1);
    assign o_stat.rem_zero  = r_rem == '0;
    assign o_stat.seen_hit  = r_seen[rem_idx];
    assign o_stat.emit_last = emit_last;
    assign o_stat.out_free  = out_free;

    rdd_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_DEN)
    ) u_seen_pos (
        .i_clk   (i_clk),
        .i_we    (i_cmd.dig_step),
        .i_waddr (rem_idx),
        .i_wdata (r_count),
        .i_re    (1'b1),
        .i_raddr (rem_idx),
        .o_rdata (seen_rdata)
    );

    rdd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DEN)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (i_cmd.dig_step),
        .i_waddr (r_count),
        .i_wdata (dig_q),
        .i_re    (dig_re),
        .i_raddr (dig_raddr),
        .o_rdata (dig_rdata)
    );

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num   <= i_numerator;
            r_den   <= i_denominator;
            r_rem   <= '0;
            r_bits  <= '0;
            r_count <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= {r_num[NUM_W-2:0], div_ge};
            r_rem  <= div_rem;
            r_bits <= r_bits + CNT_W'(1);
        end else if (i_cmd.dig_step) begin
            r_rem   <= dig_rem;
            r_count <= r_count + IDX_W'(1);
        end
        if (i_cmd.take_start) begin
            r_start <= seen_rdata;
        end
        if (dig_re) begin
            r_idx <= dig_raddr;
        end
    end

    // per-item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_repeating <= 1'b0;
        end else if (i_cmd.load) begin
            r_seen      <= '0;
            r_repeating <= 1'b0;
        end else begin
            if (i_cmd.dig_step) begin
                r_seen[rem_idx] <= 1'b1;
            end
            if (i_cmd.take_start) begin
                r_repeating <= 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_int || i_cmd.emit_dig || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_kind  <= KIND_ERR;
            r_value <= '0;
            r_rs    <= 1'b0;
            r_re    <= 1'b0;
            r_last  <= 1'b1;
        end else if (i_cmd.emit_int) begin
            r_kind  <= KIND_INT;
            r_value <= q_val;
            r_rs    <= 1'b0;
            r_re    <= 1'b0;
            r_last  <= o_stat.rem_zero;
        end else if (i_cmd.emit_dig) begin
            r_kind  <= KIND_DIGIT;
            r_value <= VALUE_W'(dig_rdata);
            r_rs    <= r_repeating && (r_idx == r_start);
            r_re    <= r_repeating && emit_last;
            r_last  <= emit_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_value        = r_value;
    assign o_repeat_start = r_rs;
    assign o_repeat_end   = r_re;
    assign o_last         = r_last;

endmodule

// ----- rtl/recurring_decimal_divider.sv -----
// ----------------------------------------------------------------------------
// recurring_decimal_divider: fraction to recurring decimal by long division
// Top level: sequencer and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
// Each accepted word (numerator, denominator) yields one integer-part word,
// then one word per fractional digit; the digit that opens a repeating group
// carries repeat_start and the final digit of a repeating expansion carries
// repeat_end; last marks the final word. A denominator of zero or above
// MAX_DENOMINATOR yields a single error word. One item is in flight at a
// time. An item passes through the accept step, the one-bit-per-cycle
// quotient divider and the integer word; if a fraction remains, the digit
// steps through the seen-remainder table with a final step that detects
// the end, a capture of the repeat start position when the digits repeat,
// the start of the read of the digit buffer RAM and then the read-back of
// each digit. An error item emits only its error word. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module recurring_decimal_divider import rdd_pkg::*; #(
    parameter int MAX_DENOMINATOR = MAX_DEN_DEF,
    parameter int NUMERATOR_WIDTH = NUM_W_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rdd_in_if.sink     i_in,
    rdd_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    rdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rdd_datapath #(
        .MAX_DEN (MAX_DENOMINATOR),
        .NUM_W   (NUMERATOR_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_numerator    (i_in.numerator),
        .i_denominator  (i_in.denominator),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_kind         (o_out.kind),
        .o_value        (o_out.value),
        .o_repeat_start (o_out.repeat_start),
        .o_repeat_end   (o_out.repeat_end),
        .o_last         (o_out.last)
    );

    assign i_in.ready = in_ready;

`ifndef NO_ASSERTIONS
    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_int || cmd.emit_dig || cmd.emit_err) |-> stat.out_free)
        else $error("word loaded while output register still occupied");

    a_emit_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.emit_int, cmd.emit_dig, cmd.emit_err}))
        else $error("more than one word loaded in a cycle");

    a_err_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_ERR) |->
        (o_out.last && o_out.value == '0 && !o_out.repeat_start && !o_out.repeat_end))
        else $error("malformed error word");

    a_digit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_DIGIT) |-> (o_out.value <= VALUE_W'(RADIX - 1)))
        else $error("fractional digit out of range");
`endif

endmodule

// ----- bench/recurring_decimal_divider_tb.sv -----
// ----------------------------------------------------------------------------
// recurring_decimal_divider_tb: self-checking bench of the recurring divider
// Feeds numerator/denominator words through the input channel with random
// gaps and stalls the result channel at random. A directed table covers the
// edge values, error denominators, terminating and repeating expansions. A
// random phase follows. Every result word is checked against the fixed word of
// its directed row or a long-division predictor kept inside the bench.
// ----------------------------------------------------------------------------
module recurring_decimal_divider_tb import rdd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 287;
    localparam int DRAIN_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        t_kind        kind;
        logic [15:0]  value;
        logic         repeat_start;
        logic         repeat_end;
        logic         last;
    } t_result;

    typedef struct packed {
        logic [15:0]  num;
        logic [6:0]   den;
        logic         fixed;
        t_kind        kind;
        logic [15:0]  value;
    } t_directed_row;

    // Rows with fixed set carry their single result word; the rest go
    // through the predictor.
    localparam t_directed_row DIRECTED_ROWS [0:22] = '{
        '{16'd0,     7'd1,   1'b1, KIND_INT, 16'd0},
        '{16'd65535, 7'd1,   1'b1, KIND_INT, 16'd65535},
        '{16'd0,     7'd0,   1'b1, KIND_ERR, 16'd0},
        '{16'd65535, 7'd0,   1'b1, KIND_ERR, 16'd0},
        '{16'd1234,  7'd65,  1'b1, KIND_ERR, 16'd0},
        '{16'd65535, 7'd127, 1'b1, KIND_ERR, 16'd0},
        '{16'd0,     7'd64,  1'b1, KIND_INT, 16'd0},
        '{16'd65472, 7'd64,  1'b1, KIND_INT, 16'd1023},
        '{16'd1,     7'd3,   1'b0, KIND_INT, 16'd0},
        '{16'd1,     7'd6,   1'b0, KIND_INT, 16'd0},
        '{16'd5,     7'd12,  1'b0, KIND_INT, 16'd0},
        '{16'd1,     7'd7,   1'b0, KIND_INT, 16'd0},
        '{16'd22,    7'd7,   1'b0, KIND_INT, 16'd0},
        '{16'd1,     7'd4,   1'b0, KIND_INT, 16'd0},
        '{16'd1,     7'd2,   1'b0, KIND_INT, 16'd0},
        '{16'd1,     7'd61,  1'b0, KIND_INT, 16'd0},
        '{16'd1,     7'd59,  1'b0, KIND_INT, 16'd0},
        '{16'd65535, 7'd64,  1'b0, KIND_INT, 16'd0},
        '{16'd65535, 7'd63,  1'b0, KIND_INT, 16'd0},
        '{16'd32768, 7'd33,  1'b0, KIND_INT, 16'd0},
        '{16'd21845, 7'd11,  1'b0, KIND_INT, 16'd0},
        '{16'd43690, 7'd13,  1'b0, KIND_INT, 16'd0},
        '{16'd77,    7'd10,  1'b0, KIND_INT, 16'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    rdd_in_if  in_if();
    rdd_out_if out_if();

    recurring_decimal_divider #(
        .MAX_DENOMINATOR(MAX_DEN_DEF),
        .NUMERATOR_WIDTH(NUM_W_DEF)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    t_result     expected_words [$];
    int          mismatch_count = 0;
    bit          calm = 1'b0;

    // Divider state as the bench tracks it
    bit          seen_flag   [MAX_DEN_DEF];
    logic [5:0]  seen_at     [MAX_DEN_DEF];
    logic [3:0]  digit_store [MAX_DEN_DEF];

    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Long division in base ten; queue the integer word and every digit word, or one error word for a bad denominator.
    function automatic void expand_fraction(input logic [15:0] num, input logic [6:0] den);
        int unsigned r;
        int unsigned n;
        int unsigned start;
        int unsigned j;
        bit          repeating;
        t_result     w;
        if (den == 7'd0 || den > MAX_DEN_DEF) begin
            w = '{KIND_ERR, 16'd0, 1'b0, 1'b0, 1'b1};
            expected_words.push_back(w);
            return;
        end
        r = num % den;
        n = 0;
        start = 0;
        repeating = 1'b0;
        for (j = 0; j < MAX_DEN_DEF; j++)
            seen_flag[j] = 1'b0;
        while (n < MAX_DEN_DEF && r != 0) begin
            if (seen_flag[r % MAX_DEN_DEF]) begin
                repeating = 1'b1;
                start = seen_at[r % MAX_DEN_DEF];
                break;
            end
            seen_flag[r % MAX_DEN_DEF] = 1'b1;
            seen_at[r % MAX_DEN_DEF] = 6'(n);
            digit_store[n] = 4'((RADIX * r) / den);
            r = (RADIX * r) % den;
            n++;
        end
        w = '{KIND_INT, 16'(num / den), 1'b0, 1'b0, n == 0};
        expected_words.push_back(w);
        for (j = 0; j < n; j++) begin
            w.kind = KIND_DIGIT;
            w.value = 16'(digit_store[j]);
            w.repeat_start = repeating && j == start;
            w.repeat_end = repeating && j + 1 == n;
            w.last = j + 1 == n;
            expected_words.push_back(w);
        end
    endfunction

    // Present one word, optionally after an idle gap, and hold until taken.
    task automatic send_word(input logic [15:0] num, input logic [6:0] den);
        int gap;
        gap = (!calm && $urandom_range(0, 1) == 1) ? gap_length() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.numerator <= num;
        in_if.denominator <= den;
        @(posedge clk);
        while (in_if.ready !== 1'b1) @(posedge clk);
    endtask

    initial begin
        int          idx;
        int unsigned pick;
        logic [15:0] num;
        logic [6:0]  den;
        t_result     w;
        in_if.valid <= 1'b0;
        in_if.numerator <= '0;
        in_if.denominator <= '0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < $size(DIRECTED_ROWS); idx++) begin
            send_word(DIRECTED_ROWS[idx].num, DIRECTED_ROWS[idx].den);
            if (DIRECTED_ROWS[idx].fixed) begin
                w = '{DIRECTED_ROWS[idx].kind, DIRECTED_ROWS[idx].value, 1'b0, 1'b0, 1'b1};
                expected_words.push_back(w);
            end else begin
                expand_fraction(DIRECTED_ROWS[idx].num, DIRECTED_ROWS[idx].den);
            end
        end

        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            // Switch between bursts without idling and bursts with gaps
            if (idx % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                den = ($urandom_range(0, 1) == 1) ? 7'd0 : 7'($urandom_range(65, 127));
            else
                den = 7'($urandom_range(1, MAX_DEN_DEF));
            pick = $urandom_range(0, 99);
            if (pick < 60)
                num = 16'($urandom_range(0, 65535));
            else if (pick < 85 || den == 7'd0 || den > MAX_DEN_DEF)
                num = 16'($urandom_range(0, 99));
            else
                num = 16'(den * $urandom_range(0, 65535 / den));
            send_word(num, den);
            expand_fraction(num, den);
        end
        in_if.valid <= 1'b0;
        calm = 1'b0;

        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = gap_length() - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word kind=%0d value=%0d rs=%0b re=%0b last=%0b",
                         $time, out_if.kind, out_if.value, out_if.repeat_start,
                         out_if.repeat_end, out_if.last);
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                if (out_if.kind !== want.kind || out_if.value !== want.value ||
                    out_if.repeat_start !== want.repeat_start ||
                    out_if.repeat_end !== want.repeat_end || out_if.last !== want.last) begin
                    $display("%0t: expected kind=%0d value=%0d rs=%0b re=%0b last=%0b",
                             $time, want.kind, want.value, want.repeat_start,
                             want.repeat_end, want.last);
                    $display("%0t: actual   kind=%0d value=%0d rs=%0b re=%0b last=%0b",
                             $time, out_if.kind, out_if.value, out_if.repeat_start,
                             out_if.repeat_end, out_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Drop the run when neither channel moves a word for too long
    always @(posedge clk) begin
        int idle_cycles;
        if (rst_n !== 1'b1) begin
            idle_cycles = 0;
        end else if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                     (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d words outstanding",
                     $time, idle_cycles, expected_words.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

endmodule
